// ===== hw/rtl/gmc_pkg.sv =====
// Shared constants, types and helper functions of the grid maze carver.
`timescale 1ns / 1ps

package gmc_pkg;

    // Grid geometry and derived widths.
    localparam int GRID_W  = 32;
    localparam int GRID_H  = 32;
    localparam int CELL_N  = GRID_W * GRID_H;
    localparam int XW      = $clog2(GRID_W);
    localparam int YW      = $clog2(GRID_H);
    localparam int CELL_AW = $clog2(CELL_N);
    localparam int DEPTH_W = $clog2(CELL_N + 1);
    localparam int STK_W   = XW + YW;

    // Fixed field widths.
    localparam int REQ_W   = 2;
    localparam int RAND_W  = 16;
    localparam int COORD_W = 5;
    localparam int EV_W    = 3;
    localparam int DIR_W   = 2;
    localparam int WALL_W  = 4;
    localparam int CELL_W  = 5;
    localparam int VIS_BIT = 4;

    // Neighbor scan order: left, right, bottom, top.
    localparam int NB_N = 4;
    localparam int K_W  = 2;
    localparam logic [K_W-1:0] NB_LEFT   = 2'd0;
    localparam logic [K_W-1:0] NB_RIGHT  = 2'd1;
    localparam logic [K_W-1:0] NB_BOTTOM = 2'd2;
    localparam logic [K_W-1:0] NB_TOP    = 2'd3;

    // Cell word: walls in bits 3..0, visited mark in bit 4.
    localparam logic [CELL_W-1:0] CELL_RESET  = 5'b01111;
    localparam logic [CELL_W-1:0] CELL_ORIGIN = 5'b10111;

    typedef enum logic [REQ_W-1:0] {
        REQ_START = 2'd0,
        REQ_STEP  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef enum logic [EV_W-1:0] {
        EV_CARVED  = 3'd0,
        EV_BACK    = 3'd1,
        EV_DONE    = 3'd2,
        EV_READ    = 3'd3,
        EV_IGNORED = 3'd4
    } t_event;

    typedef enum logic [DIR_W-1:0] {
        DIR_LEFT   = 2'd0,
        DIR_TOP    = 2'd1,
        DIR_RIGHT  = 2'd2,
        DIR_BOTTOM = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CARVE = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        RES_START,
        RES_IGNORE,
        RES_CARVE,
        RES_BACK,
        RES_DONE,
        RES_READ
    } t_res;

    typedef enum logic [4:0] {
        S_RST_CLR,
        S_IDLE,
        S_START_CLR,
        S_START_WR,
        S_STK,
        S_TOP,
        S_NB,
        S_SELF,
        S_PICK,
        S_WR_SELF,
        S_WR_NB,
        S_POP,
        S_FIN_RD,
        S_FIN_WR,
        S_RD_ISSUE,
        S_RD_DATA,
        S_IGN,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic start_init;
        logic stk_rd;
        logic top_load;
        logic nb_issue;
        logic nb_take;
        logic self_rd;
        logic self_take;
        logic pick_load;
        logic wr_self;
        logic wr_nb;
        logic pop;
        logic fin_rd;
        logic fin_wr;
        logic rd_issue;
        logic res_load;
        t_res res_sel;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic k_first;
        logic k_last;
        logic can_step;
        logic any_free;
        logic last_pop;
        logic rd_in_range;
        logic out_free;
    } t_stat;

    function automatic logic [CELL_AW-1:0] f_cell_addr(input logic [XW-1:0] x,
                                                       input logic [YW-1:0] y);
        return CELL_AW'(y) * CELL_AW'(GRID_W) + CELL_AW'(x);
    endfunction

    function automatic logic [XW-1:0] f_nb_x(input logic [XW-1:0] x,
                                             input logic [K_W-1:0] k);
        logic [XW-1:0] r;
        case (k)
            NB_LEFT:  r = x - XW'(1);
            NB_RIGHT: r = x + XW'(1);
            default:  r = x;
        endcase
        return r;
    endfunction

    function automatic logic [YW-1:0] f_nb_y(input logic [YW-1:0] y,
                                             input logic [K_W-1:0] k);
        logic [YW-1:0] r;
        case (k)
            NB_BOTTOM: r = y - YW'(1);
            NB_TOP:    r = y + YW'(1);
            default:   r = y;
        endcase
        return r;
    endfunction

    function automatic t_dir f_nb_dir(input logic [K_W-1:0] k);
        t_dir r;
        case (k)
            NB_LEFT:   r = DIR_LEFT;
            NB_RIGHT:  r = DIR_RIGHT;
            NB_BOTTOM: r = DIR_BOTTOM;
            default:   r = DIR_TOP;
        endcase
        return r;
    endfunction

    // Remainder by three: 4 is 1 mod 3, so the base-4 digit sum keeps the remainder.
    function automatic logic [1:0] f_mod3(input logic [RAND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < RAND_W / 2; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    // Index of the chosen candidate: value mod count, count in 1..4.
    function automatic logic [K_W-1:0] f_pick_index(input logic [RAND_W-1:0] v,
                                                    input logic [2:0] count);
        logic [K_W-1:0] r;
        case (count)
            3'd2:    r = K_W'(v[0]);
            3'd3:    r = f_mod3(v);
            3'd4:    r = v[1:0];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] f_count4(input logic [NB_N-1:0] m);
        logic [2:0] c;
        c = '0;
        for (int i = 0; i < NB_N; i++) begin
            c = c + 3'(m[i]);
        end
        return c;
    endfunction

    // Position of the p-th set bit of the mask, counting from bit 0.
    function automatic logic [K_W-1:0] f_nth_set(input logic [NB_N-1:0] m,
                                                 input logic [K_W-1:0] p);
        logic [K_W-1:0] r;
        logic [2:0] seen;
        r = '0;
        seen = '0;
        for (int i = 0; i < NB_N; i++) begin
            if (m[i]) begin
                if (seen == 3'(p)) begin
                    r = K_W'(i);
                end
                seen = seen + 3'd1;
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/grid_maze_carver_core.sv =====
// Top level of the grid maze carver: controller, datapath and channel ports.
`timescale 1ns / 1ps
// A start runs a one-cell-per-cycle wall sweep over the cell memory before it writes the
// origin cell. A carving step is paced by the single read port of the cell memory (four
// neighbor reads and one own-cell read) behind one stack read. The controller raises
// o_in_ready for the next request in the cycle after the result is loaded into the output
// register, so it works on one request at a time.
// Reset runs a clearing pass over all CELL_N cells of the cell memory; o_in_ready stays low.

module grid_maze_carver_core
    import gmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [RAND_W-1:0]  i_rand_value,
    input  logic [COORD_W-1:0] i_read_x,
    input  logic [COORD_W-1:0] i_read_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [EV_W-1:0]    o_event_res,
    output logic [COORD_W-1:0] o_cell_x,
    output logic [COORD_W-1:0] o_cell_y,
    output logic [DIR_W-1:0]   o_direction,
    output logic [WALL_W-1:0]  o_walls,
    output logic               o_visited,
    output logic               o_maze_done
);

    // The controller sequences each request as a string of single-port memory
    // operations; the datapath holds the cell store, the path stack, the cursor
    // cell and the result staging and output registers.
    t_cmd  cmd;
    t_stat st;

    gmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_st       (st),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // The output register parts the two channels: a finished result may wait for
    // its transfer while the controller already takes and works on the next request.
    gmc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_rand_value (i_rand_value),
        .i_read_x     (i_read_x),
        .i_read_y     (i_read_y),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_event_res  (o_event_res),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_direction  (o_direction),
        .o_walls      (o_walls),
        .o_visited    (o_visited),
        .o_maze_done  (o_maze_done)
    );

endmodule

// ===== hw/rtl/gmc_ctrl.sv =====
// Sequencing state machine of the grid maze carver.
`timescale 1ns / 1ps

module gmc_ctrl
    import gmc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [REQ_W-1:0] i_req_type,
    input  t_stat            i_st,
    output logic             o_in_ready,
    output t_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RST_CLR: begin
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_req'(i_req_type))
                        REQ_START: n_state = S_START_CLR;
                        REQ_STEP:  n_state = i_st.can_step ? S_STK : S_IGN;
                        REQ_READ:  n_state = S_RD_ISSUE;
                        default:   n_state = S_IGN;
                    endcase
                end
            end
            S_START_CLR: begin
                if (i_st.clr_last) begin
                    n_state = S_START_WR;
                end
            end
            S_START_WR: n_state = S_OUT;
            S_STK:      n_state = S_TOP;
            S_TOP:      n_state = S_NB;
            S_NB: begin
                if (i_st.k_last) begin
                    n_state = S_SELF;
                end
            end
            S_SELF:     n_state = S_PICK;
            S_PICK:     n_state = i_st.any_free ? S_WR_SELF : S_POP;
            S_WR_SELF:  n_state = S_WR_NB;
            S_WR_NB:    n_state = S_OUT;
            S_POP:      n_state = i_st.last_pop ? S_FIN_RD : S_OUT;
            S_FIN_RD:   n_state = S_FIN_WR;
            S_FIN_WR:   n_state = S_OUT;
            S_RD_ISSUE: n_state = i_st.rd_in_range ? S_RD_DATA : S_OUT;
            S_RD_DATA:  n_state = S_OUT;
            S_IGN:      n_state = S_OUT;
            S_OUT: begin
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_RST_CLR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_START_CLR: o_cmd.clr_wr = 1'b1;
            S_START_WR: begin
                o_cmd.start_init = 1'b1;
                o_cmd.res_load   = 1'b1;
                o_cmd.res_sel    = RES_START;
            end
            S_STK: o_cmd.stk_rd = 1'b1;
            S_TOP: o_cmd.top_load = 1'b1;
            S_NB: begin
                o_cmd.nb_issue = 1'b1;
                o_cmd.nb_take  = !i_st.k_first;
            end
            S_SELF: begin
                o_cmd.self_rd = 1'b1;
                o_cmd.nb_take = 1'b1;
            end
            S_PICK: begin
                o_cmd.self_take = 1'b1;
                o_cmd.pick_load = 1'b1;
            end
            S_WR_SELF: o_cmd.wr_self = 1'b1;
            S_WR_NB: begin
                o_cmd.wr_nb    = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_CARVE;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                if (!i_st.last_pop) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_BACK;
                end
            end
            S_FIN_RD: o_cmd.fin_rd = 1'b1;
            S_FIN_WR: begin
                o_cmd.fin_wr   = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_DONE;
            end
            S_RD_ISSUE: begin
                if (i_st.rd_in_range) begin
                    o_cmd.rd_issue = 1'b1;
                end else begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_IGNORE;
                end
            end
            S_RD_DATA: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_READ;
            end
            S_IGN: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_IGNORE;
            end
            S_OUT: o_cmd.out_load = i_st.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/gmc_dpath.sv =====
// Datapath of the grid maze carver: cell and stack memories, cursor and result registers.
`timescale 1ns / 1ps

module gmc_dpath
    import gmc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_st,
    input  logic [RAND_W-1:0]  i_rand_value,
    input  logic [COORD_W-1:0] i_read_x,
    input  logic [COORD_W-1:0] i_read_y,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [EV_W-1:0]    o_event_res,
    output logic [COORD_W-1:0] o_cell_x,
    output logic [COORD_W-1:0] o_cell_y,
    output logic [DIR_W-1:0]   o_direction,
    output logic [WALL_W-1:0]  o_walls,
    output logic               o_visited,
    output logic               o_maze_done
);

    logic [CELL_W-1:0] mem_cell [CELL_N];
    logic [STK_W-1:0]  mem_stk  [CELL_N];

    // Control registers.
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;
    t_phase             r_phase;
    t_phase             n_phase;
    logic [CELL_AW-1:0] r_clr_addr;
    logic [K_W-1:0]     r_k;
    logic               r_out_valid;

    // Payload registers.
    logic [RAND_W-1:0]  r_rand;
    logic [COORD_W-1:0] r_rx;
    logic [COORD_W-1:0] r_ry;
    logic [XW-1:0]      r_cx;
    logic [YW-1:0]      r_cy;
    logic [CELL_W-1:0]  r_nb [NB_N];
    logic [CELL_W-1:0]  r_self;
    logic [K_W-1:0]     r_pick;
    logic [CELL_W-1:0]  r_cell_rd;
    logic [STK_W-1:0]   r_stk_rd;

    t_event             r_res_ev;
    logic [COORD_W-1:0] r_res_x;
    logic [COORD_W-1:0] r_res_y;
    t_dir               r_res_dir;
    logic [CELL_W-1:0]  r_res_cell;

    t_event             r_out_ev;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    t_dir               r_out_dir;
    logic [CELL_W-1:0]  r_out_cell;
    logic               r_out_done;

    // Neighbor bookkeeping.
    logic [NB_N-1:0]    exist;
    logic [NB_N-1:0]    avail;
    logic [2:0]         cnt;
    logic [XW-1:0]      iss_x;
    logic [YW-1:0]      iss_y;
    logic [XW-1:0]      pk_x;
    logic [YW-1:0]      pk_y;
    t_dir               pk_dir;
    logic [DIR_W-1:0]   pk_opp;
    logic [K_W-1:0]     take_k;
    logic [CELL_AW-1:0] self_addr;
    logic [CELL_AW-1:0] iss_addr;
    logic [CELL_AW-1:0] pk_addr;
    logic [CELL_AW-1:0] rd_addr;
    logic [CELL_AW-1:0] last_addr;
    logic [CELL_W-1:0]  self_new;
    logic [CELL_W-1:0]  nb_new;
    logic [CELL_W-1:0]  fin_new;
    logic               stk_full;
    logic [DEPTH_W-1:0] depth_m1;

    // Memory port controls.
    logic               cw_en;
    logic [CELL_AW-1:0] cw_addr;
    logic [CELL_W-1:0]  cw_data;
    logic               cr_en;
    logic [CELL_AW-1:0] cr_addr;
    logic               sw_en;
    logic [CELL_AW-1:0] sw_addr;
    logic [STK_W-1:0]   sw_data;

    always_comb begin
        exist[NB_LEFT]   = r_cx != '0;
        exist[NB_RIGHT]  = r_cx != XW'(GRID_W - 1);
        exist[NB_BOTTOM] = r_cy != '0;
        exist[NB_TOP]    = r_cy != YW'(GRID_H - 1);
        for (int i = 0; i < NB_N; i++) begin
            avail[i] = exist[i] & ~r_nb[i][VIS_BIT];
        end
    end

    assign cnt       = f_count4(avail);
    assign take_k    = r_k - K_W'(1);
    assign iss_x     = exist[r_k] ? f_nb_x(r_cx, r_k) : r_cx;
    assign iss_y     = exist[r_k] ? f_nb_y(r_cy, r_k) : r_cy;
    assign pk_x      = f_nb_x(r_cx, r_pick);
    assign pk_y      = f_nb_y(r_cy, r_pick);
    assign pk_dir    = f_nb_dir(r_pick);
    assign pk_opp    = pk_dir ^ 2'b10;
    assign self_addr = f_cell_addr(r_cx, r_cy);
    assign iss_addr  = f_cell_addr(iss_x, iss_y);
    assign pk_addr   = f_cell_addr(pk_x, pk_y);
    assign rd_addr   = f_cell_addr(XW'(r_rx), YW'(r_ry));
    assign last_addr = f_cell_addr(XW'(GRID_W - 1), YW'(GRID_H - 1));
    assign self_new  = r_self & ~(CELL_W'(1) << pk_dir);
    assign nb_new    = (r_nb[r_pick] & ~(CELL_W'(1) << pk_opp)) | (CELL_W'(1) << VIS_BIT);
    assign fin_new   = r_cell_rd & ~(CELL_W'(1) << DIR_TOP);
    assign stk_full  = r_depth == DEPTH_W'(CELL_N);
    assign depth_m1  = r_depth - DEPTH_W'(1);

    // Cell memory write port.
    always_comb begin
        cw_en   = 1'b1;
        cw_addr = '0;
        cw_data = '0;
        if (i_cmd.clr_wr) begin
            cw_addr = r_clr_addr;
            cw_data = CELL_RESET;
        end else if (i_cmd.start_init) begin
            cw_data = CELL_ORIGIN;
        end else if (i_cmd.wr_self) begin
            cw_addr = self_addr;
            cw_data = self_new;
        end else if (i_cmd.wr_nb) begin
            cw_addr = pk_addr;
            cw_data = nb_new;
        end else if (i_cmd.fin_wr) begin
            cw_addr = last_addr;
            cw_data = fin_new;
        end else begin
            cw_en = 1'b0;
        end
    end

    // Cell memory read port.
    always_comb begin
        cr_en   = 1'b1;
        cr_addr = '0;
        if (i_cmd.nb_issue) begin
            cr_addr = iss_addr;
        end else if (i_cmd.self_rd) begin
            cr_addr = self_addr;
        end else if (i_cmd.fin_rd) begin
            cr_addr = last_addr;
        end else if (i_cmd.rd_issue) begin
            cr_addr = rd_addr;
        end else begin
            cr_en = 1'b0;
        end
    end

    // Stack write port: the origin on start, the entered cell on a carve.
    assign sw_en   = i_cmd.start_init | (i_cmd.wr_nb & ~stk_full);
    assign sw_addr = i_cmd.start_init ? '0 : r_depth[CELL_AW-1:0];
    assign sw_data = i_cmd.start_init ? '0 : {pk_y, pk_x};

    always_ff @(posedge i_clk) begin
        if (cw_en) begin
            mem_cell[cw_addr] <= cw_data;
        end
        if (cr_en) begin
            r_cell_rd <= mem_cell[cr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sw_en) begin
            mem_stk[sw_addr] <= sw_data;
        end
        if (i_cmd.stk_rd) begin
            r_stk_rd <= mem_stk[depth_m1[CELL_AW-1:0]];
        end
    end

    always_comb begin
        n_depth = r_depth;
        if (i_cmd.start_init) begin
            n_depth = DEPTH_W'(1);
        end else if (i_cmd.wr_nb && !stk_full) begin
            n_depth = r_depth + DEPTH_W'(1);
        end else if (i_cmd.pop) begin
            n_depth = depth_m1;
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (i_cmd.start_init) begin
            n_phase = PH_CARVE;
        end else if (i_cmd.fin_wr) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_phase     <= PH_IDLE;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_phase <= n_phase;
            if (i_cmd.clr_wr) begin
                r_clr_addr <= o_st.clr_last ? '0 : r_clr_addr + CELL_AW'(1);
            end
            if (i_cmd.top_load) begin
                r_k <= '0;
            end else if (i_cmd.nb_issue) begin
                r_k <= r_k + K_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rand <= i_rand_value;
            r_rx   <= i_read_x;
            r_ry   <= i_read_y;
        end
        if (i_cmd.top_load) begin
            {r_cy, r_cx} <= r_stk_rd;
        end
        if (i_cmd.nb_take) begin
            r_nb[take_k] <= r_cell_rd;
        end
        if (i_cmd.self_take) begin
            r_self <= r_cell_rd;
        end
        if (i_cmd.pick_load) begin
            r_pick <= f_nth_set(avail, f_pick_index(r_rand, cnt));
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RES_START: begin
                    r_res_ev   <= EV_CARVED;
                    r_res_x    <= '0;
                    r_res_y    <= '0;
                    r_res_dir  <= DIR_BOTTOM;
                    r_res_cell <= CELL_ORIGIN;
                end
                RES_CARVE: begin
                    r_res_ev   <= EV_CARVED;
                    r_res_x    <= COORD_W'(pk_x);
                    r_res_y    <= COORD_W'(pk_y);
                    r_res_dir  <= pk_dir;
                    r_res_cell <= nb_new;
                end
                RES_BACK, RES_DONE: begin
                    r_res_ev   <= (i_cmd.res_sel == RES_DONE) ? EV_DONE : EV_BACK;
                    r_res_x    <= COORD_W'(r_cx);
                    r_res_y    <= COORD_W'(r_cy);
                    r_res_dir  <= DIR_LEFT;
                    r_res_cell <= r_self;
                end
                RES_READ: begin
                    r_res_ev   <= EV_READ;
                    r_res_x    <= r_rx;
                    r_res_y    <= r_ry;
                    r_res_dir  <= DIR_LEFT;
                    r_res_cell <= r_cell_rd;
                end
                default: begin
                    r_res_ev   <= EV_IGNORED;
                    r_res_x    <= '0;
                    r_res_y    <= '0;
                    r_res_dir  <= DIR_LEFT;
                    r_res_cell <= '0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_ev   <= r_res_ev;
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
            r_out_dir  <= r_res_dir;
            r_out_cell <= r_res_cell;
            r_out_done <= r_phase == PH_DONE;
        end
    end

    always_comb begin
        o_st.clr_last    = r_clr_addr == CELL_AW'(CELL_N - 1);
        o_st.k_first     = r_k == '0;
        o_st.k_last      = r_k == K_W'(NB_N - 1);
        o_st.can_step    = (r_phase == PH_CARVE) && (r_depth != '0);
        o_st.any_free    = |avail;
        o_st.last_pop    = r_depth == DEPTH_W'(1);
        o_st.rd_in_range = (int'(r_rx) < GRID_W) && (int'(r_ry) < GRID_H);
        o_st.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_out_ev;
    assign o_cell_x    = r_out_x;
    assign o_cell_y    = r_out_y;
    assign o_direction = r_out_dir;
    assign o_walls     = r_out_cell[WALL_W-1:0];
    assign o_visited   = r_out_cell[VIS_BIT];
    assign o_maze_done = r_out_done;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(CELL_N))
        else $error("stack depth beyond cell count");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_depth == '0))
        else $error("finished maze with cells left on the stack");

    a_pick_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_nb |-> (avail[r_pick] && !stk_full))
        else $error("carve into a visited or missing neighbor");

    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_init |=> ((r_depth == DEPTH_W'(1)) && (r_phase == PH_CARVE)))
        else $error("start did not seed the stack");

    a_out_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

endmodule
